FILE: rtl/type_length_payload_deframer_unit_defines.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; each user module must have clk and rst_n in scope.
`ifndef TYPE_LENGTH_PAYLOAD_DEFRAMER_UNIT_DEFINES_SVH
`define TYPE_LENGTH_PAYLOAD_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlpd_pkg.sv
// Shared types for the type-length-payload deframer.
// No dependencies.
`timescale 1ns / 1ps

package tlpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned MAXLEN_W = 16;

  // One result transaction, parser to output buffer.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              frame_done;
    logic [WORD_W-1:0] frame_type;
    logic [WORD_W-1:0] frame_length;
    logic              heartbeat_mark;
    logic              oversize_error;
  } tlpd_result_t;

endpackage

FILE: rtl/tlpd_cfg_regs.sv
// APB-style configuration register block: max payload length.
// Depends on tlpd_pkg.
`timescale 1ns / 1ps

module tlpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [tlpd_pkg::MAXLEN_W-1:0]  max_len
);
  import tlpd_pkg::*;

  localparam logic       REG_MAX_PAYLOAD_LEN = 1'b0;
  localparam logic [MAXLEN_W-1:0] MaxLenReset = 16'd1024;

  logic                wr_en;
  logic                reg_idx;
  logic [MAXLEN_W-1:0] max_len_r;

  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else if (wr_en && (reg_idx == REG_MAX_PAYLOAD_LEN)) begin
      max_len_r <= cfg_pwdata[MAXLEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_MAX_PAYLOAD_LEN) begin
      cfg_prdata = {{(32-MAXLEN_W){1'b0}}, max_len_r};
    end
  end

  assign max_len = max_len_r;

endmodule

FILE: rtl/tlpd_parser.sv
// Frame parser: segment state, byte counter and header word assembly.
// Depends on tlpd_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "type_length_payload_deframer_unit_defines.svh"

module tlpd_parser #(
  parameter int unsigned HEADER_FIELD_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [tlpd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [tlpd_pkg::MAXLEN_W-1:0]  max_len,
  output tlpd_pkg::tlpd_result_t         result
);
  import tlpd_pkg::*;

  typedef enum logic [3:0] {
    SEG_TYPE = 4'b0001,
    SEG_LEN  = 4'b0010,
    SEG_PAY  = 4'b0100,
    SEG_SKIP = 4'b1000
  } tlpd_seg_t;

  localparam logic [WORD_W-1:0] FieldBytes = WORD_W'(HEADER_FIELD_BYTES);

  // Little-endian byte insert; lane k clears the word at the start of a field.
  // Lanes past the fourth fall off the word.
  function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] word,
                                                 input logic [2:0] k,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    w = (k == 3'd0) ? '0 : word;
    for (int j = 0; j < 4; j++) begin
      if (k == 3'(j)) begin
        w[8*j +: 8] = b;
      end
    end
    return w;
  endfunction

  tlpd_seg_t         seg_r, seg_nxt;
  logic [WORD_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [WORD_W-1:0] type_word_r, type_word_nxt;
  logic [WORD_W-1:0] length_word_r, length_word_nxt;

  logic [WORD_W-1:0] field_pos;
  logic [2:0]        lane;
  logic              last;
  logic [WORD_W-1:0] dec;
  logic              done;
  logic              err;
  logic              pvalid;

  assign field_pos = FieldBytes - bytes_left_r;
  assign lane      = field_pos[2:0];
  assign last      = (bytes_left_r <= 32'd1);
  assign dec       = bytes_left_r - 32'd1;

  always_comb begin
    seg_nxt         = seg_r;
    bytes_left_nxt  = bytes_left_r;
    type_word_nxt   = type_word_r;
    length_word_nxt = length_word_r;
    done            = 1'b0;
    err             = 1'b0;
    pvalid          = 1'b0;
    case (seg_r)
      SEG_TYPE: begin
        type_word_nxt = put_byte(type_word_r, lane, data_byte);
        if (last) begin
          seg_nxt        = SEG_LEN;
          bytes_left_nxt = FieldBytes;
        end else begin
          bytes_left_nxt = dec;
        end
      end
      SEG_LEN: begin
        length_word_nxt = put_byte(length_word_r, lane, data_byte);
        if (last) begin
          if (length_word_nxt > {{(WORD_W-MAXLEN_W){1'b0}}, max_len}) begin
            err            = 1'b1;
            seg_nxt        = SEG_SKIP;
            bytes_left_nxt = length_word_nxt;
          end else if (length_word_nxt == '0) begin
            // empty frame completes on its last length byte
            done           = 1'b1;
            seg_nxt        = SEG_TYPE;
            bytes_left_nxt = FieldBytes;
          end else begin
            seg_nxt        = SEG_PAY;
            bytes_left_nxt = length_word_nxt;
          end
        end else begin
          bytes_left_nxt = dec;
        end
      end
      SEG_PAY: begin
        pvalid = 1'b1;
        if (last) begin
          done           = 1'b1;
          seg_nxt        = SEG_TYPE;
          bytes_left_nxt = FieldBytes;
        end else begin
          bytes_left_nxt = dec;
        end
      end
      default: begin
        // skipping an oversize payload
        if (last) begin
          done           = 1'b1;
          err            = 1'b1;
          seg_nxt        = SEG_TYPE;
          bytes_left_nxt = FieldBytes;
        end else begin
          bytes_left_nxt = dec;
        end
      end
    endcase
  end

  always_comb begin
    result.payload_byte   = pvalid ? data_byte : '0;
    result.payload_valid  = pvalid;
    result.frame_done     = done;
    result.frame_type     = done ? type_word_nxt : '0;
    result.frame_length   = done ? length_word_nxt : '0;
    result.heartbeat_mark = done && (type_word_nxt == '0);
    result.oversize_error = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r         <= SEG_TYPE;
      bytes_left_r  <= FieldBytes;
      type_word_r   <= '0;
      length_word_r <= '0;
    end else if (accept) begin
      seg_r         <= seg_nxt;
      bytes_left_r  <= bytes_left_nxt;
      type_word_r   <= type_word_nxt;
      length_word_r <= length_word_nxt;
    end
  end

  `TLPD_ASSERT_NOW(a_no_done_in_type, accept && (seg_r == SEG_TYPE), !result.frame_done,
    "frame completed inside the type field")
  `TLPD_ASSERT_NEXT(a_pay_end_restarts, accept && (seg_r == SEG_PAY) && last,
    (seg_r == SEG_TYPE) && (bytes_left_r == FieldBytes),
    "payload end did not restart the header")
  `TLPD_ASSERT_NEXT(a_oversize_skips, accept && result.oversize_error && !result.frame_done,
    (seg_r == SEG_SKIP) && (bytes_left_r != '0),
    "oversize length did not enter the skip segment")

endmodule

FILE: rtl/tlpd_out_buf.sv
// Output register plus one skid entry for the result channel.
// Depends on tlpd_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "type_length_payload_deframer_unit_defines.svh"

module tlpd_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tlpd_pkg::tlpd_result_t push_data,
  output logic                   full,
  input  logic                   out_stall,
  output logic                   out_valid,
  output tlpd_pkg::tlpd_result_t out_data
);
  import tlpd_pkg::*;

  logic         out_valid_r;
  logic         skid_valid_r;
  tlpd_result_t out_data_r;
  tlpd_result_t skid_data_r;
  logic         slot_free;

  // output register may load when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TLPD_ASSERT_NOW(a_skid_implies_out, skid_valid_r, out_valid_r,
    "skid entry held with empty output register")
  `TLPD_ASSERT_NEXT(a_skid_fills, push && out_valid_r && out_stall, skid_valid_r,
    "stalled transaction not captured in skid entry")
  `TLPD_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r,
    "skid entry not moved to the output register")

endmodule

FILE: rtl/type_length_payload_deframer_unit.sv
// Type-length-payload deframer, top level.
// Uses tlpd_pkg, tlpd_cfg_regs, tlpd_parser and tlpd_out_buf.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) carries the framed
//   byte stream, one byte per transaction. A frame is a type field, a length
//   field (HEADER_FIELD_BYTES bytes each, little-endian) and then the payload.
//   Result channel (out_valid / out_stall / out_*) gives exactly one result
//   transaction per input byte, in order.
//   Each result is registered in the output register, or first in the skid entry while the receiver stalls.
//   Throughput: one byte per cycle while in_stall is low; per-byte work is a decrement, an insert and a compare.
//   Stalls: an output register plus one skid entry sit behind the parser, so
//   a byte is still taken in the cycle the receiver starts stalling; in_stall
//   rises only once the skid entry holds a transaction.
//   Reset (rst_n low, synchronous): the parser returns to the start of a type
//   field, both buffers empty, max_payload_length goes to 1024.
//   Config: max_payload_length at byte address 0 on the cfg_ port; write it
//   only while no transaction is in flight.
//   Lengths above max_payload_length flag oversize_error on the last length
//   byte and again, with frame_done, on the last skipped payload byte.
`timescale 1ns / 1ps

module type_length_payload_deframer_unit #(
  parameter int unsigned HEADER_FIELD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // results out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic        out_frame_done,
  output logic [31:0] out_frame_type,
  output logic [31:0] out_frame_length,
  output logic        out_heartbeat_mark,
  output logic        out_oversize_error,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tlpd_pkg::*;

  logic                in_accept;
  logic                buf_full;
  logic [MAXLEN_W-1:0] max_len;
  tlpd_result_t        parse_res;
  tlpd_result_t        out_res;

  // stall only when the skid entry is occupied
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  tlpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  // state advances on every accepted byte; result is formed the same cycle
  tlpd_parser #(
    .HEADER_FIELD_BYTES (HEADER_FIELD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .max_len   (max_len),
    .result    (parse_res)
  );

  tlpd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (parse_res),
    .full      (buf_full),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  assign out_payload_byte   = out_res.payload_byte;
  assign out_payload_valid  = out_res.payload_valid;
  assign out_frame_done     = out_res.frame_done;
  assign out_frame_type     = out_res.frame_type;
  assign out_frame_length   = out_res.frame_length;
  assign out_heartbeat_mark = out_res.heartbeat_mark;
  assign out_oversize_error = out_res.oversize_error;

endmodule
